FILE: hdl/psrl_pkg.sv
// shared types and constants for the per-source connection rate limiter
// no dependencies
package psrl_pkg;

    localparam int TABLE_ENTRIES = 256;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    localparam logic [1:0] OP_CONNECT = 2'd0;
    localparam logic [1:0] OP_LOOKUP  = 2'd1;
    localparam logic [1:0] OP_REMOVE  = 2'd2;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX    = 2'd1;

    localparam logic [15:0] COUNT_MAX = 16'hffff;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] source_addr;
        logic [31:0] now_seconds;
    } cmd_t;

    typedef struct packed {
        logic        allowed;
        logic        found;
        logic        blocked_now;
        logic        echo_hit;
        logic [31:0] first_seen;
        logic [31:0] last_seen;
        logic [15:0] hit_count;
    } result_t;

    typedef struct packed {
        logic [31:0] window_seconds;
        logic [15:0] max_connects;
    } cfg_t;

    typedef struct packed {
        logic [CNT_W-1:0] occupancy;
        logic             idle;
    } status_t;

    typedef struct packed {
        logic [31:0] addr;
        logic [31:0] first_time;
        logic [31:0] last_time;
        logic [15:0] count;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EXEC,
        ST_SWEEP,
        ST_INSERT
    } state_t;

endpackage

FILE: hdl/psrl_ram.sv
// generic synchronous ram, one write port and one registered read port
// no dependencies
module psrl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: hdl/psrl_engine.sv
// table scan, judge and write-back sequencer around the entry memory
// depends on psrl_pkg and psrl_ram
module psrl_engine
    import psrl_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    start,
    input  cmd_t    cmd,
    output logic    busy,
    output logic    done,
    output result_t result,
    output status_t status
);

    localparam logic [CNT_W-1:0] TABLE_END = CNT_W'(TABLE_ENTRIES);

    state_t                   state_reg, state_next;
    logic [1:0]               op_reg, op_next;
    logic [31:0]              addr_reg, addr_next;
    logic [31:0]              now_reg, now_next;
    logic [CNT_W-1:0]         idx_reg, idx_next;
    logic                     pend_reg, pend_next;
    logic [IDX_W-1:0]         pidx_reg, pidx_next;
    logic [IDX_W-1:0]         slot_reg, slot_next;
    logic                     hit_reg, hit_next;
    entry_t                   ent_reg, ent_next;
    logic [IDX_W-1:0]         free_reg, free_next;
    logic                     free_ok_reg, free_ok_next;
    logic [TABLE_ENTRIES-1:0] valid_reg, valid_next;
    logic [CNT_W-1:0]         occ_reg, occ_next;
    result_t                  res_reg, res_next;
    logic                     done_reg, done_next;

    logic             ram_we, ram_re;
    logic [IDX_W-1:0] ram_waddr, ram_raddr;
    entry_t           ram_wdata, ram_rdata;

    logic [31:0] el_first, el_last, sw_el;
    logic        scan_hit;

    psrl_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_ENTRIES)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    function automatic logic [15:0] bump(input logic [15:0] c);
        return (c < COUNT_MAX) ? c + 16'd1 : COUNT_MAX;
    endfunction

    assign el_first = now_reg - ent_reg.first_time;
    assign el_last  = now_reg - ent_reg.last_time;
    assign sw_el    = now_reg - ram_rdata.last_time;
    assign scan_hit = pend_reg && valid_reg[pidx_reg] && (ram_rdata.addr == addr_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            pend_reg    <= 1'b0;
            free_ok_reg <= 1'b0;
            valid_reg   <= '0;
            occ_reg     <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            pend_reg    <= pend_next;
            free_ok_reg <= free_ok_next;
            valid_reg   <= valid_next;
            occ_reg     <= occ_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        addr_reg <= addr_next;
        now_reg  <= now_next;
        idx_reg  <= idx_next;
        pidx_reg <= pidx_next;
        slot_reg <= slot_next;
        hit_reg  <= hit_next;
        ent_reg  <= ent_next;
        free_reg <= free_next;
        res_reg  <= res_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        addr_next    = addr_reg;
        now_next     = now_reg;
        idx_next     = idx_reg;
        pend_next    = 1'b0;
        pidx_next    = pidx_reg;
        slot_next    = slot_reg;
        hit_next     = hit_reg;
        ent_next     = ent_reg;
        free_next    = free_reg;
        free_ok_next = free_ok_reg;
        valid_next   = valid_reg;
        occ_next     = occ_reg;
        res_next     = res_reg;
        done_next    = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = slot_reg;
        ram_wdata    = ent_reg;
        ram_re       = 1'b0;
        ram_raddr    = idx_reg[IDX_W-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    op_next      = cmd.op;
                    addr_next    = cmd.source_addr;
                    now_next     = cmd.now_seconds;
                    idx_next     = '0;
                    hit_next     = 1'b0;
                    free_ok_next = 1'b0;
                    if (cmd.op inside {OP_CONNECT, OP_LOOKUP, OP_REMOVE})
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_EXEC;
                    end
                end
            end

            ST_SCAN:
            begin
                if (pend_reg && !valid_reg[pidx_reg] && !free_ok_reg)
                begin
                    free_next    = pidx_reg;
                    free_ok_next = 1'b1;
                end
                if (scan_hit)
                begin
                    hit_next   = 1'b1;
                    slot_next  = pidx_reg;
                    ent_next   = ram_rdata;
                    state_next = ST_EXEC;
                end
                else if (idx_reg != TABLE_END)
                begin
                    ram_re    = 1'b1;
                    pend_next = 1'b1;
                    pidx_next = idx_reg[IDX_W-1:0];
                    idx_next  = idx_reg + 1'b1;
                end
                else if (!pend_reg)
                begin
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                res_next   = '0;
                done_next  = 1'b1;
                state_next = ST_IDLE;
                case (op_reg)
                    OP_CONNECT:
                    begin
                        res_next.allowed = 1'b1;
                        res_next.found   = hit_reg;
                        if (!hit_reg)
                        begin
                            done_next = 1'b0;
                            if (occ_reg >= TABLE_END)
                            begin
                                idx_next     = '0;
                                free_ok_next = 1'b0;
                                state_next   = ST_SWEEP;
                            end
                            else
                            begin
                                state_next = ST_INSERT;
                            end
                        end
                        else
                        begin
                            ram_we = 1'b1;
                            ram_wdata.last_time = now_reg;
                            if (ent_reg.count < cfg.max_connects)
                            begin
                                if (el_first > cfg.window_seconds)
                                begin
                                    ram_wdata.count      = 16'd1;
                                    ram_wdata.first_time = now_reg;
                                end
                                else
                                begin
                                    ram_wdata.count = bump(ent_reg.count);
                                end
                            end
                            else if (el_last > cfg.window_seconds)
                            begin
                                ram_wdata.count      = 16'd1;
                                ram_wdata.first_time = now_reg;
                            end
                            else
                            begin
                                ram_wdata.count  = bump(ent_reg.count);
                                res_next.allowed = 1'b0;
                            end
                        end
                    end
                    OP_LOOKUP:
                    begin
                        res_next.found = hit_reg;
                        if (hit_reg)
                        begin
                            res_next.allowed     = 1'b1;
                            res_next.blocked_now = (ent_reg.count >= cfg.max_connects) &&
                                                   (el_first <= cfg.window_seconds);
                            if ((ent_reg.count > cfg.max_connects) &&
                                (el_last <= cfg.window_seconds))
                            begin
                                res_next.echo_hit   = 1'b1;
                                res_next.first_seen = ent_reg.first_time;
                                res_next.last_seen  = ent_reg.last_time;
                                res_next.hit_count  = ent_reg.count;
                            end
                        end
                    end
                    OP_REMOVE:
                    begin
                        res_next.allowed = 1'b1;
                        res_next.found   = hit_reg;
                        if (hit_reg)
                        begin
                            valid_next[slot_reg] = 1'b0;
                            if (occ_reg != '0)
                            begin
                                occ_next = occ_reg - 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        res_next = '0;
                    end
                endcase
            end

            ST_SWEEP:
            begin
                if (pend_reg && valid_reg[pidx_reg] && (sw_el >= cfg.window_seconds))
                begin
                    valid_next[pidx_reg] = 1'b0;
                    if (occ_reg != '0)
                    begin
                        occ_next = occ_reg - 1'b1;
                    end
                    if (!free_ok_reg)
                    begin
                        free_next    = pidx_reg;
                        free_ok_next = 1'b1;
                    end
                end
                if (idx_reg != TABLE_END)
                begin
                    ram_re    = 1'b1;
                    pend_next = 1'b1;
                    pidx_next = idx_reg[IDX_W-1:0];
                    idx_next  = idx_reg + 1'b1;
                end
                else if (!pend_reg)
                begin
                    state_next = ST_INSERT;
                end
            end

            ST_INSERT:
            begin
                res_next         = '0;
                res_next.allowed = 1'b1;
                done_next        = 1'b1;
                state_next       = ST_IDLE;
                if (free_ok_reg)
                begin
                    ram_we               = 1'b1;
                    ram_waddr            = free_reg;
                    ram_wdata.addr       = addr_reg;
                    ram_wdata.first_time = now_reg;
                    ram_wdata.last_time  = now_reg;
                    ram_wdata.count      = 16'd1;
                    valid_next[free_reg] = 1'b1;
                    occ_next             = occ_reg + 1'b1;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy             = (state_reg != ST_IDLE);
    assign done             = done_reg;
    assign result           = res_reg;
    assign status.occupancy = occ_reg;
    assign status.idle      = (state_reg == ST_IDLE);

endmodule

FILE: hdl/per_source_connection_rate_limiter_top.sv
// top level: configuration registers and the rate limiter engine
// depends on psrl_pkg, psrl_engine and psrl_ram
//
// a command is taken when start is high and busy is low; its single result
// appears for one cycle with done and cannot be held off. each command with a
// defined op scans the source table in memory one entry per cycle until a
// match, through the single read port of the entry memory; a miss scans the
// whole table, and a connect that misses then inserts the source. a connect
// from an unknown source on a full table adds a sweep of the table before the
// insert. an undefined op skips the scan. no clearing pass is needed after
// reset.
module per_source_connection_rate_limiter_top
    import psrl_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  cmd_t                 cmd,
    output logic                 busy,
    output logic                 done,
    output result_t              result,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    cfg_t    cfg_reg;
    status_t status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_seconds <= 32'd60;
            cfg_reg.max_connects   <= 16'd10;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_WINDOW: cfg_reg.window_seconds <= cfg_data;
                REG_MAX:    cfg_reg.max_connects   <= cfg_data[15:0];
                default:    ;
            endcase
        end
    end

    psrl_engine u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .start  (start),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done),
        .result (result),
        .status (status)
    );

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result transfer without a command in flight");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not make the block busy");

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        status.occupancy <= CNT_W'(TABLE_ENTRIES))
        else $error("occupancy above table size");

    a_idle_flag: assert property (@(posedge clk) disable iff (!rst_n)
        status.idle == !busy)
        else $error("idle status disagrees with busy");

endmodule

FILE: sim/tb_top.sv
// self-checking testbench for per_source_connection_rate_limiter_top
// depends on psrl_pkg and the rate limiter rtl; holds its own source table predictor
`timescale 1ns / 100ps

module tb_top;
    import psrl_pkg::*;

    localparam logic [1:0]           OP_UNDEF  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd2;
    localparam int                   STALL_LIMIT = 5000;

    class rate_scoreboard;
        bit          vld [TABLE_ENTRIES];
        logic [31:0] src [TABLE_ENTRIES];
        logic [31:0] t_first [TABLE_ENTRIES];
        logic [31:0] t_last [TABLE_ENTRIES];
        logic [15:0] conn_cnt [TABLE_ENTRIES];
        int          occupancy;
        logic [31:0] window;
        logic [15:0] limit;
        result_t     pending [$];
        int          errors;

        function new();
            foreach (vld[i]) vld[i] = 0;
            occupancy = 0;
            window = 60;
            limit = 10;
            errors = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
            if (idx == REG_WINDOW)
                window = val;
            else if (idx == REG_MAX)
                limit = val[15:0];
        endfunction

        function logic [15:0] bump(logic [15:0] c);
            return (c < COUNT_MAX) ? c + 16'd1 : COUNT_MAX;
        endfunction

        function void drop(int i);
            vld[i] = 0;
            if (occupancy > 0)
                occupancy--;
        endfunction

        function void admit(logic [31:0] a, logic [31:0] now);
            int freed;
            int slot;
            freed = 0;
            slot = -1;
            if (occupancy >= TABLE_ENTRIES) begin
                for (int i = 0; i < TABLE_ENTRIES; i++)
                    if (vld[i] && (now - t_last[i]) >= window) begin
                        drop(i);
                        freed++;
                    end
                if (freed == 0)
                    return;
            end
            for (int i = 0; i < TABLE_ENTRIES; i++)
                if (!vld[i]) begin
                    slot = i;
                    break;
                end
            if (slot < 0)
                return;
            vld[slot] = 1;
            src[slot] = a;
            t_first[slot] = now;
            t_last[slot] = now;
            conn_cnt[slot] = 16'd1;
            occupancy++;
        endfunction

        // accepted command transfer: update table and queue the expected result
        function void note(cmd_t c);
            result_t r;
            int s;
            logic [31:0] now;
            r = '0;
            s = -1;
            now = c.now_seconds;
            for (int i = 0; i < TABLE_ENTRIES; i++)
                if (vld[i] && src[i] == c.source_addr) begin
                    s = i;
                    break;
                end
            r.found = (s >= 0);
            case (c.op)
                OP_CONNECT: begin
                    r.allowed = 1;
                    if (s < 0)
                        admit(c.source_addr, now);
                    else if (conn_cnt[s] < limit) begin
                        if ((now - t_first[s]) > window) begin
                            conn_cnt[s] = 0;
                            t_first[s] = now;
                        end
                        conn_cnt[s] = bump(conn_cnt[s]);
                        t_last[s] = now;
                    end else if ((now - t_last[s]) > window) begin
                        conn_cnt[s] = 16'd1;
                        t_first[s] = now;
                        t_last[s] = now;
                    end else begin
                        conn_cnt[s] = bump(conn_cnt[s]);
                        t_last[s] = now;
                        r.allowed = 0;
                    end
                end
                OP_LOOKUP: begin
                    if (s >= 0) begin
                        r.allowed = 1;
                        r.blocked_now = conn_cnt[s] >= limit && (now - t_first[s]) <= window;
                        r.echo_hit = conn_cnt[s] > limit && (now - t_last[s]) <= window;
                        if (r.echo_hit) begin
                            r.first_seen = t_first[s];
                            r.last_seen = t_last[s];
                            r.hit_count = conn_cnt[s];
                        end
                    end
                end
                OP_REMOVE: begin
                    r.allowed = 1;
                    if (s >= 0)
                        drop(s);
                end
                default: r = '0;
            endcase
            pending.push_back(r);
        endfunction

        task report(string what, logic [31:0] exp_v, logic [31:0] got_v);
            $display("%0t mismatch %s: expected %h got %h", $realtime, what, exp_v, got_v);
            errors++;
        endtask

        task check(result_t r);
            result_t e;
            if (pending.size() == 0) begin
                report("unexpected result", 0, r.allowed);
                return;
            end
            e = pending.pop_front();
            if (r.allowed !== e.allowed) report("allowed", e.allowed, r.allowed);
            if (r.found !== e.found) report("found", e.found, r.found);
            if (r.blocked_now !== e.blocked_now) report("blocked_now", e.blocked_now, r.blocked_now);
            if (r.echo_hit !== e.echo_hit) report("echo_hit", e.echo_hit, r.echo_hit);
            if (r.first_seen !== e.first_seen) report("first_seen", e.first_seen, r.first_seen);
            if (r.last_seen !== e.last_seen) report("last_seen", e.last_seen, r.last_seen);
            if (r.hit_count !== e.hit_count) report("hit_count", e.hit_count, r.hit_count);
        endtask
    endclass

    logic                 clk = 0;
    logic                 rst_n = 0;
    logic                 start = 0;
    cmd_t                 cmd = '0;
    logic                 busy;
    logic                 done;
    result_t              result;
    logic                 cfg_we = 0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data = '0;

    rate_scoreboard sb = new();
    bit          start_hi = 0;
    int          burst_left = 0;
    int          idle_cycles = 0;
    logic [31:0] clock_now = 0;
    logic [31:0] pool [12];

    always #1 clk = ~clk;

    per_source_connection_rate_limiter_top dut (
        .clk(clk), .rst_n(rst_n), .start(start), .cmd(cmd), .busy(busy),
        .done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always @(posedge clk) begin
        if (rst_n && start && !busy)
            sb.note(cmd);
        if (rst_n && done)
            sb.check(result);
        if ((start && !busy) || done || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task send(logic [1:0] op, logic [31:0] a, logic [31:0] now);
        int gap;
        start <= 1;
        cmd <= '{op: op, source_addr: a, now_seconds: now};
        start_hi = 1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (burst_left > 0)
            burst_left--;
        else begin
            burst_left = $urandom_range(0, 15);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                start <= 0;
                start_hi = 0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task drain();
        if (start_hi) begin
            start <= 0;
            start_hi = 0;
        end
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        sb.set_reg(idx, val);
        @(posedge clk);
        cfg_we <= 0;
        @(posedge clk);
    endtask

    task configure(logic [31:0] win, logic [15:0] lim);
        drain();
        write_reg(REG_WINDOW, win);
        write_reg(REG_MAX, {16'h0, lim});
    endtask

    task random_items(int n);
        logic [1:0]  op;
        logic [31:0] a;
        int          pick;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(0, 99);
            op = (pick < 60) ? OP_CONNECT : (pick < 85) ? OP_LOOKUP :
                 (pick < 95) ? OP_REMOVE : OP_UNDEF;
            a = ($urandom_range(0, 99) < 85) ? pool[$urandom_range(0, 11)] : $urandom;
            pick = $urandom_range(0, 99);
            if (pick < 70)
                clock_now = clock_now + $urandom_range(0, 3);
            else if (pick < 80)
                clock_now = clock_now + sb.window;
            else if (pick < 90)
                clock_now = clock_now + sb.window + 1;
            else
                clock_now = $urandom;
            send(op, a, clock_now);
        end
    endtask

    initial begin
        foreach (pool[i])
            pool[i] = $urandom;
        pool[0] = 32'h0;
        pool[1] = 32'hffff_ffff;
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // small window and limit with a time wrap
        configure(32'd5, 16'd2);
        write_reg(REG_SPARE, 32'hdead_beef);
        send(OP_CONNECT, 32'hffff_ffff, 32'hffff_fffe);
        send(OP_CONNECT, 32'hffff_ffff, 32'hffff_fffe);
        send(OP_CONNECT, 32'hffff_ffff, 32'hffff_ffff);
        send(OP_LOOKUP,  32'hffff_ffff, 32'hffff_ffff);
        send(OP_CONNECT, 32'hffff_ffff, 32'd1);
        send(OP_LOOKUP,  32'hffff_ffff, 32'd2);
        send(OP_CONNECT, 32'hffff_ffff, 32'd20);
        send(OP_CONNECT, 32'hffff_ffff, 32'd21);
        send(OP_CONNECT, 32'hffff_ffff, 32'd40);
        send(OP_CONNECT, 32'h0, 32'd0);
        send(OP_LOOKUP,  32'h0, 32'd0);
        send(OP_LOOKUP,  32'h1234_5678, 32'd3);
        send(OP_REMOVE,  32'hffff_ffff, 32'd41);
        send(OP_REMOVE,  32'hffff_ffff, 32'd42);
        send(OP_LOOKUP,  32'hffff_ffff, 32'd43);
        send(OP_UNDEF,   32'h0, 32'd44);
        send(OP_REMOVE,  32'h0, 32'd45);
        clock_now = 32'd100;
        random_items(150);

        // fill the table, overflow untracked, then sweep idle entries
        configure(32'd60, 16'd10);
        for (int i = 0; i < TABLE_ENTRIES + 4; i++)
            send(OP_CONNECT, 32'h0a00_0000 + i, (i < TABLE_ENTRIES) ? 32'd1000 : 32'd1010);
        send(OP_LOOKUP, 32'h0a00_0000 + TABLE_ENTRIES, 32'd1011);
        send(OP_CONNECT, 32'h0b00_0000, 32'd1100);
        send(OP_LOOKUP, 32'h0a00_0001, 32'd1100);
        clock_now = 32'd1200;
        random_items(200);

        configure(32'd0, 16'd0);
        random_items(200);
        configure(32'hffff_ffff, 16'hffff);
        random_items(200);
        configure(32'd3, 16'd1);
        random_items(200);
        configure(32'd1000, 16'd4);
        random_items(200);

        drain();
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
